// ===== hdl/nnu_pkg.sv =====
// shared constants and types for the nearest-neighbor upscaler
package nnu_pkg;

   localparam int WIDTH_MAX   = 1024;
   localparam int SCALE_MAX   = 100;
   localparam int ADDR_W      = $clog2(WIDTH_MAX);
   localparam int WIDTH_W     = 11;
   localparam int SCALE_W     = 7;
   localparam int HEIGHT_W    = 16;
   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = HEIGHT_W;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd2;

   typedef struct packed {
      logic       err;
      logic [1:0] pad;
      logic       row_end;
      logic       frame_end;
   } rsp_meta_type;

endpackage

// ===== hdl/nnu_ram.sv =====
// generic single-write, single-read ram with registered read data
module nnu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/nearest_neighbor_upscaler.sv =====
// nearest-neighbor upscaler top level: counters, line store and result pipeline
//
// Usage: the request channel (req_valid/req_stall) carries commands. A load
// (req_command = 0) writes one source pixel into the line store at the next
// free column; it produces no result and is dropped once the row is full.
// A pull (req_command = 1) produces exactly one result transaction on the
// response channel (rsp_valid/rsp_stall): the next output pixel in raster
// order with row_end, frame_end and pad_bytes, or status 1 with zero color
// when the current source row is not completely loaded yet.
// A pull's result passes through the line store read register and then the
// output register before it is presented on the response channel.
// Throughput: one transaction per cycle on either command while req_stall is low;
// the line store has one write port for loads and one read port for pulls.
// Reset clears all counters and sets scale, width and height to 1. Any csr
// write (indexes 0..2) also restarts the frame; write csrs only while idle.
// When the receiver stalls, the output register and the read stage hold;
// req_stall rises only once both are full, and no transaction is lost.
module nearest_neighbor_upscaler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [nnu_pkg::COLOR_W-1:0]        req_blue_in,
   input  logic [nnu_pkg::COLOR_W-1:0]        req_green_in,
   input  logic [nnu_pkg::COLOR_W-1:0]        req_red_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nnu_pkg::COLOR_W-1:0]        rsp_blue_out,
   output logic [nnu_pkg::COLOR_W-1:0]        rsp_green_out,
   output logic [nnu_pkg::COLOR_W-1:0]        rsp_red_out,
   output logic [1:0]                         rsp_pad_bytes,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end,
   output logic                               rsp_status,
   input  logic                               csr_wr_en,
   input  logic [nnu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [nnu_pkg::SCALE_W-1:0] SCALE_LIMIT =
      nnu_pkg::SCALE_W'(nnu_pkg::SCALE_MAX);
   localparam logic [nnu_pkg::WIDTH_W-1:0] WIDTH_LIMIT =
      nnu_pkg::WIDTH_W'(nnu_pkg::WIDTH_MAX);

   // configuration
   logic [nnu_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic [nnu_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [nnu_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic                         restart;

   // frame counters
   logic [nnu_pkg::WIDTH_W-1:0]  loaded_ff, loaded_in;
   logic [nnu_pkg::ADDR_W-1:0]   column_ff, column_in;
   logic [nnu_pkg::SCALE_W-1:0]  hcopy_ff, hcopy_in;
   logic [nnu_pkg::SCALE_W-1:0]  vcopy_ff, vcopy_in;
   logic [nnu_pkg::HEIGHT_W-1:0] row_ff, row_in;

   // pipeline
   logic                         s1_valid_ff, s1_valid_in;
   nnu_pkg::rsp_meta_type        s1_meta_ff, s1_meta_in;
   logic                         out_valid_ff, out_valid_in;
   nnu_pkg::rsp_meta_type        out_meta_ff, out_meta_in;
   logic [nnu_pkg::PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;
   logic [nnu_pkg::PIXEL_W-1:0]  ram_rdata;

   logic [nnu_pkg::SCALE_W-1:0]  s_eff;
   logic [nnu_pkg::WIDTH_W-1:0]  w_eff;
   logic [nnu_pkg::HEIGHT_W-1:0] h_eff;
   logic                         req_fire, load_fire, pull_fire, good_pull;
   logic                         row_ready, h_last, c_last, v_last, r_last;
   logic                         row_end, frame_end, out_load;
   logic [3:0]                   pad_prod;

   assign s_eff = (scale_ff == '0) ? nnu_pkg::SCALE_W'(1) :
                  (scale_ff > SCALE_LIMIT) ? SCALE_LIMIT : scale_ff;
   assign w_eff = (width_ff == '0) ? nnu_pkg::WIDTH_W'(1) :
                  (width_ff > WIDTH_LIMIT) ? WIDTH_LIMIT : width_ff;
   assign h_eff = (height_ff == '0) ? nnu_pkg::HEIGHT_W'(1) : height_ff;

   assign req_fire  = req_valid && !req_stall;
   assign load_fire = req_fire && (req_command == nnu_pkg::CMD_LOAD);
   assign pull_fire = req_fire && (req_command == nnu_pkg::CMD_PULL);
   assign row_ready = !(loaded_ff < w_eff);
   assign good_pull = pull_fire && row_ready;

   assign h_last = ({1'b0, hcopy_ff} + (nnu_pkg::SCALE_W + 1)'(1)) == {1'b0, s_eff};
   assign v_last = ({1'b0, vcopy_ff} + (nnu_pkg::SCALE_W + 1)'(1)) == {1'b0, s_eff};
   assign c_last = (nnu_pkg::WIDTH_W'(column_ff) + nnu_pkg::WIDTH_W'(1)) == w_eff;
   assign r_last = ({1'b0, row_ff} + (nnu_pkg::HEIGHT_W + 1)'(1)) == {1'b0, h_eff};
   assign row_end   = c_last && h_last;
   assign frame_end = row_end && v_last && r_last;

   // (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
   assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};

   // csr writes
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            nnu_pkg::CSR_SCALE: begin
               scale_in = csr_wdata[nnu_pkg::SCALE_W-1:0];
               restart  = 1'b1;
            end
            nnu_pkg::CSR_WIDTH: begin
               width_in = csr_wdata[nnu_pkg::WIDTH_W-1:0];
               restart  = 1'b1;
            end
            nnu_pkg::CSR_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // counter advance
   always_comb begin
      loaded_in = loaded_ff;
      column_in = column_ff;
      hcopy_in  = hcopy_ff;
      vcopy_in  = vcopy_ff;
      row_in    = row_ff;
      if (restart) begin
         loaded_in = '0;
         column_in = '0;
         hcopy_in  = '0;
         vcopy_in  = '0;
         row_in    = '0;
      end else if (load_fire && !row_ready) begin
         loaded_in = loaded_ff + nnu_pkg::WIDTH_W'(1);
      end else if (good_pull) begin
         hcopy_in = hcopy_ff + nnu_pkg::SCALE_W'(1);
         if (h_last) begin
            hcopy_in  = '0;
            column_in = column_ff + nnu_pkg::ADDR_W'(1);
            if (c_last) begin
               column_in = '0;
               vcopy_in  = vcopy_ff + nnu_pkg::SCALE_W'(1);
               if (v_last) begin
                  vcopy_in  = '0;
                  loaded_in = '0;
                  row_in    = r_last ? '0 : row_ff + nnu_pkg::HEIGHT_W'(1);
               end
            end
         end
      end
   end

   nnu_ram #(
      .WIDTH (nnu_pkg::PIXEL_W),
      .DEPTH (nnu_pkg::WIDTH_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (load_fire && !row_ready),
      .wr_addr (loaded_ff[nnu_pkg::ADDR_W-1:0]),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (good_pull),
      .rd_addr (column_ff),
      .rd_data (ram_rdata)
   );

   // read stage and output register
   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;

   always_comb begin
      s1_meta_in = s1_meta_ff;
      if (pull_fire) begin
         s1_meta_in.err       = !row_ready;
         s1_meta_in.pad       = (row_ready && row_end) ? pad_prod[1:0] : 2'd0;
         s1_meta_in.row_end   = row_ready && row_end;
         s1_meta_in.frame_end = row_ready && frame_end;
      end
      s1_valid_in = pull_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);

      out_meta_in  = out_meta_ff;
      out_pixel_in = out_pixel_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_meta_in  = s1_meta_ff;
         out_pixel_in = s1_meta_ff.err ? '0 : ram_rdata;
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= nnu_pkg::SCALE_W'(1);
         width_ff     <= nnu_pkg::WIDTH_W'(1);
         height_ff    <= nnu_pkg::HEIGHT_W'(1);
         loaded_ff    <= '0;
         column_ff    <= '0;
         hcopy_ff     <= '0;
         vcopy_ff     <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         loaded_ff    <= loaded_in;
         column_ff    <= column_in;
         hcopy_ff     <= hcopy_in;
         vcopy_ff     <= vcopy_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff   <= s1_meta_in;
      out_meta_ff  <= out_meta_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_blue_out  = out_pixel_ff[nnu_pkg::COLOR_W-1:0];
   assign rsp_green_out = out_pixel_ff[2*nnu_pkg::COLOR_W-1:nnu_pkg::COLOR_W];
   assign rsp_red_out   = out_pixel_ff[3*nnu_pkg::COLOR_W-1:2*nnu_pkg::COLOR_W];
   assign rsp_pad_bytes = out_meta_ff.pad;
   assign rsp_row_end   = out_meta_ff.row_end;
   assign rsp_frame_end = out_meta_ff.frame_end;
   assign rsp_status    = out_meta_ff.err;

   // load count never runs past the row width
   assert property (@(posedge clock) disable iff (reset) loaded_ff <= w_eff)
      else $error("loaded count exceeds row width");

   // horizontal and vertical copy indexes stay below the scale
   assert property (@(posedge clock) disable iff (reset)
      (hcopy_ff < s_eff) && (vcopy_ff < s_eff))
      else $error("copy index out of range");

   // an accepted pull always reaches the read stage
   assert property (@(posedge clock) disable iff (reset)
      pull_fire |=> s1_valid_ff)
      else $error("pull transaction lost");

   // an early-pull response carries no pixel and no row markers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (out_pixel_ff == '0) && !rsp_row_end && !rsp_frame_end && (rsp_pad_bytes == 2'd0))
      else $error("error response carries data");

   // frame end only at the end of a row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame end without row end");

endmodule

// ===== bench/nnu_checker.sv =====
// result checker for the nearest-neighbor upscaler: mirrors the pixel counters and compares
module nnu_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic [nnu_pkg::COLOR_W-1:0]     req_blue_in,
   input  logic [nnu_pkg::COLOR_W-1:0]     req_green_in,
   input  logic [nnu_pkg::COLOR_W-1:0]     req_red_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [nnu_pkg::COLOR_W-1:0]     rsp_blue_out,
   input  logic [nnu_pkg::COLOR_W-1:0]     rsp_green_out,
   input  logic [nnu_pkg::COLOR_W-1:0]     rsp_red_out,
   input  logic [1:0]                      rsp_pad_bytes,
   input  logic                            rsp_row_end,
   input  logic                            rsp_frame_end,
   input  logic                            rsp_status,
   input  logic                            csr_wr_en,
   input  logic [nnu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              pending,
   output int                              pixels_checked,
   output int                              early_pulls,
   output int                              frame_ends,
   output int                              dropped_loads
);

   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [nnu_pkg::COLOR_W-1:0] blue;
      logic [nnu_pkg::COLOR_W-1:0] green;
      logic [nnu_pkg::COLOR_W-1:0] red;
      nnu_pkg::rsp_meta_type       meta;
   } out_pixel_type;

   out_pixel_type upcoming_pixels[$];

   logic [nnu_pkg::PIXEL_W-1:0]  row_pixels [nnu_pkg::WIDTH_MAX];
   logic [nnu_pkg::WIDTH_W-1:0]  loaded;
   logic [nnu_pkg::ADDR_W-1:0]   column;
   logic [nnu_pkg::SCALE_W-1:0]  hcopy;
   logic [nnu_pkg::SCALE_W-1:0]  vcopy;
   logic [nnu_pkg::HEIGHT_W-1:0] src_row;
   logic [nnu_pkg::SCALE_W-1:0]  scale_reg;
   logic [nnu_pkg::WIDTH_W-1:0]  width_reg;
   logic [nnu_pkg::HEIGHT_W-1:0] height_reg;

   function automatic int eff_scale();
      if (scale_reg == '0) return 1;
      if (int'(scale_reg) > nnu_pkg::SCALE_MAX) return nnu_pkg::SCALE_MAX;
      return int'(scale_reg);
   endfunction

   function automatic int eff_width();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > nnu_pkg::WIDTH_MAX) return nnu_pkg::WIDTH_MAX;
      return int'(width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg == '0) ? 1 : int'(height_reg);
   endfunction

   function automatic void restart_frame();
      loaded  = '0;
      column  = '0;
      hcopy   = '0;
      vcopy   = '0;
      src_row = '0;
   endfunction

   // works out the next output pixel and steps the raster counters
   function automatic out_pixel_type next_pixel();
      int                          s;
      int                          w;
      int                          h;
      logic [nnu_pkg::PIXEL_W-1:0] pix;
      out_pixel_type               o;
      s = eff_scale();
      w = eff_width();
      h = eff_height();
      o = '0;
      if (int'(loaded) < w) begin
         // row not complete yet: error status, nothing moves
         o.meta.err = 1'b1;
         return o;
      end
      pix = row_pixels[column];
      o.blue  = pix[7:0];
      o.green = pix[15:8];
      o.red   = pix[23:16];
      o.meta.row_end   = (int'(column) + 1 == w) && (int'(hcopy) + 1 == s);
      o.meta.frame_end = o.meta.row_end && (int'(vcopy) + 1 == s) && (int'(src_row) + 1 == h);
      if (o.meta.row_end) o.meta.pad = 2'((4 - ((3 * w * s) % 4)) % 4);
      if (int'(hcopy) + 1 < s) begin
         hcopy++;
      end else begin
         hcopy = '0;
         if (int'(column) + 1 < w) begin
            column++;
         end else begin
            column = '0;
            if (int'(vcopy) + 1 < s) begin
               vcopy++;
            end else begin
               vcopy  = '0;
               loaded = '0;
               if (int'(src_row) + 1 < h) src_row++;
               else src_row = '0;
            end
         end
      end
      return o;
   endfunction

   task automatic report(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED)
         $display("mismatch in %s after %0d pixels: got 0x%0h, expected 0x%0h",
                  what, pixels_checked, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report(what, got, want);
   endtask

   always @(posedge clock) begin
      out_pixel_type want;
      if (reset) begin
         restart_frame();
         scale_reg  = nnu_pkg::SCALE_W'(1);
         width_reg  = nnu_pkg::WIDTH_W'(1);
         height_reg = nnu_pkg::HEIGHT_W'(1);
         upcoming_pixels.delete();
         mismatches     = 0;
         pixels_checked = 0;
         early_pulls    = 0;
         frame_ends     = 0;
         dropped_loads  = 0;
      end else begin
         // results first, so a pull never pairs with a result of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (upcoming_pixels.size() == 0) begin
               report("result with no pull outstanding", int'(rsp_status), 0);
            end else begin
               want = upcoming_pixels.pop_front();
               check_field("blue", int'(rsp_blue_out), int'(want.blue));
               check_field("green", int'(rsp_green_out), int'(want.green));
               check_field("red", int'(rsp_red_out), int'(want.red));
               check_field("pad_bytes", int'(rsp_pad_bytes), int'(want.meta.pad));
               check_field("row_end", int'(rsp_row_end), int'(want.meta.row_end));
               check_field("frame_end", int'(rsp_frame_end), int'(want.meta.frame_end));
               check_field("status", int'(rsp_status), int'(want.meta.err));
               pixels_checked++;
               if (want.meta.err) early_pulls++;
               if (want.meta.frame_end) frame_ends++;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               nnu_pkg::CSR_SCALE: begin
                  scale_reg = csr_wdata[nnu_pkg::SCALE_W-1:0];
                  restart_frame();
               end
               nnu_pkg::CSR_WIDTH: begin
                  width_reg = csr_wdata[nnu_pkg::WIDTH_W-1:0];
                  restart_frame();
               end
               nnu_pkg::CSR_HEIGHT: begin
                  height_reg = csr_wdata[nnu_pkg::HEIGHT_W-1:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_command == nnu_pkg::CMD_PULL) begin
               upcoming_pixels.push_back(next_pixel());
            end else if (int'(loaded) < eff_width()) begin
               row_pixels[loaded[nnu_pkg::ADDR_W-1:0]] = {req_red_in, req_green_in, req_blue_in};
               loaded++;
            end else begin
               dropped_loads++;
            end
         end
      end
      pending <= upcoming_pixels.size();
   end

endmodule

// ===== bench/tb_nearest_neighbor_upscaler.sv =====
// testbench top for the nearest-neighbor upscaler: stimulus, receiver stalls and verdict
module tb_nearest_neighbor_upscaler;

   // no register behind this index
   localparam logic [nnu_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS    = 1100;
   localparam int MIN_SETTINGS    = 7;
   localparam int ROW_PULL_CAP    = 60;
   localparam int DRAIN_LIMIT     = 5000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {
      SETUP_SMALL, SETUP_WIDE, SETUP_BIG_SCALE, SETUP_ANY, SETUP_PRESSURE
   } setup_kind_type;

   logic                            clock;
   logic                            reset        = 1'b1;
   logic                            req_valid    = 1'b0;
   logic                            req_stall;
   logic                            req_command  = nnu_pkg::CMD_LOAD;
   logic [nnu_pkg::COLOR_W-1:0]     req_blue_in  = '0;
   logic [nnu_pkg::COLOR_W-1:0]     req_green_in = '0;
   logic [nnu_pkg::COLOR_W-1:0]     req_red_in   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall    = 1'b0;
   logic [nnu_pkg::COLOR_W-1:0]     rsp_blue_out;
   logic [nnu_pkg::COLOR_W-1:0]     rsp_green_out;
   logic [nnu_pkg::COLOR_W-1:0]     rsp_red_out;
   logic [1:0]                      rsp_pad_bytes;
   logic                            rsp_row_end;
   logic                            rsp_frame_end;
   logic                            rsp_status;
   logic                            csr_wr_en    = 1'b0;
   logic [nnu_pkg::CSR_INDEX_W-1:0] csr_index    = nnu_pkg::CSR_SCALE;
   logic [nnu_pkg::CSR_DATA_W-1:0]  csr_wdata    = '0;

   int mismatches;
   int pending;
   int pixels_checked;
   int early_pulls;
   int frame_ends;
   int dropped_loads;

   logic hold_active   = 1'b0;
   int   stall_pct     = 0;
   int   send_idle_pct = 0;
   int   eff_s;
   int   eff_w;
   int   eff_h;
   int   total_items   = 0;
   int   random_count  = 0;
   int   settings_done = 0;
   event hold_off_start;

   nearest_neighbor_upscaler i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_pad_bytes (rsp_pad_bytes),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   nnu_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_pad_bytes  (rsp_pad_bytes),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .pending        (pending),
      .pixels_checked (pixels_checked),
      .early_pulls    (early_pulls),
      .frame_ends     (frame_ends),
      .dropped_loads  (dropped_loads)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
   end

   // long receiver hold-off so the pipeline fills and backs up into the request side
   initial forever begin
      @(hold_off_start);
      hold_active <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   initial begin
      #4000000;
      $display("timed out with %0d pixels still outstanding", pending);
      $display("FAILURE");
      $finish;
   end

   // holds one transaction until it is taken
   task automatic send_item(input logic cmd, input logic [nnu_pkg::PIXEL_W-1:0] color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_blue_in  <= color[7:0];
      req_green_in <= color[15:8];
      req_red_in   <= color[23:16];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      total_items++;
   endtask

   task automatic load_pixel(input logic [nnu_pkg::PIXEL_W-1:0] color);
      send_item(nnu_pkg::CMD_LOAD, color);
   endtask

   task automatic pull_pixel();
      send_item(nnu_pkg::CMD_PULL, nnu_pkg::PIXEL_W'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // loads leave nothing to wait for, let the pipeline idle anyway
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [nnu_pkg::CSR_INDEX_W-1:0] idx, input int data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= nnu_pkg::CSR_DATA_W'(data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int scale_data, input int width_data, input int height_data,
                            input bit with_spare);
      int s;
      int w;
      settle();
      if (with_spare) write_csr(CSR_SPARE, int'($urandom_range(0, 65535)));
      write_csr(nnu_pkg::CSR_SCALE, scale_data);
      write_csr(nnu_pkg::CSR_WIDTH, width_data);
      write_csr(nnu_pkg::CSR_HEIGHT, height_data);
      s = scale_data % 128;
      w = width_data % 2048;
      eff_s = (s == 0) ? 1 : ((s > nnu_pkg::SCALE_MAX) ? nnu_pkg::SCALE_MAX : s);
      eff_w = (w == 0) ? 1 : ((w > nnu_pkg::WIDTH_MAX) ? nnu_pkg::WIDTH_MAX : w);
      eff_h = (height_data % 65536 == 0) ? 1 : height_data % 65536;
      settings_done++;
   endtask

   // one source row: loads with the odd early pull, then its output pixels with dropped loads
   task automatic send_source_row(output bit truncated);
      int pulls;
      for (int i = 0; i < eff_w; i++) begin
         if ($urandom_range(99) < 6) begin
            pull_pixel();
            random_count++;
         end
         load_pixel(nnu_pkg::PIXEL_W'($urandom));
         random_count++;
      end
      if ($urandom_range(99) < 8) load_pixel(nnu_pkg::PIXEL_W'($urandom));
      pulls = eff_w * eff_s * eff_s;
      truncated = pulls > ROW_PULL_CAP;
      if (truncated) pulls = ROW_PULL_CAP;
      for (int i = 0; i < pulls; i++) begin
         if ($urandom_range(99) < 4) load_pixel(nnu_pkg::PIXEL_W'($urandom));
         pull_pixel();
         random_count++;
      end
   endtask

   task automatic random_setting(input int phase);
      setup_kind_type kind;
      idle_mode_type  mode;
      int             r;
      int             s;
      int             w;
      int             h;
      r = $urandom_range(9);
      if (phase == 1) kind = SETUP_WIDE;
      else if (phase == 2) kind = SETUP_PRESSURE;
      else if (phase == 3 || r == 9) kind = SETUP_BIG_SCALE;
      else if (r >= 7) kind = SETUP_ANY;
      else kind = SETUP_SMALL;
      case (kind)
         SETUP_SMALL: begin
            s = $urandom_range(1, 3);
            w = $urandom_range(1, 5);
            h = $urandom_range(0, 2);
         end
         SETUP_WIDE: begin
            s = $urandom_range(0, 2);
            w = $urandom_range(nnu_pkg::WIDTH_MAX, 2047);
            h = $urandom_range(0, 65535);
         end
         SETUP_BIG_SCALE: begin
            s = $urandom_range(nnu_pkg::SCALE_MAX - 5, 127);
            w = $urandom_range(0, 2);
            h = $urandom_range(0, 2);
         end
         SETUP_ANY: begin
            s = $urandom_range(0, 127);
            w = $urandom_range(0, 8);
            h = $urandom_range(0, 65535);
         end
         default: begin
            s = 3;
            w = 4;
            h = 2;
         end
      endcase
      // unused upper bits of the narrow registers carry noise
      s += 128 * $urandom_range(0, 511);
      w += 2048 * $urandom_range(0, 31);
      configure(s, w, h, $urandom_range(3) == 0);
      mode = (kind == SETUP_PRESSURE) ? IDLE_NONE : idle_mode_type'(phase % 4);
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct = 77;
            stall_pct    <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct    <= 77;
         end
         IDLE_BOTH: begin
            send_idle_pct = 7;
            stall_pct    <= 7;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct    <= 0;
         end
      endcase
      if (kind == SETUP_PRESSURE) -> hold_off_start;
   endtask

   initial begin
      int phase;
      int n_rows;
      int drain_cycles;
      bit truncated;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one pixel wide, no scaling
      pull_pixel();
      load_pixel(24'hffffff);
      load_pixel(24'h000000);
      pull_pixel();
      pull_pixel();

      // zeros in every register act as one
      configure(0, 0, 0, 1'b0);
      load_pixel(24'h000000);
      pull_pixel();

      // scale above the clip point, tallest frame, spare index must not restart
      configure(16'hffff, 2, 16'hffff, 1'b0);
      load_pixel(24'h563412);
      settle();
      write_csr(CSR_SPARE, 16'hffff);
      load_pixel(24'hefcdab);
      pull_pixel();
      pull_pixel();
      pull_pixel();

      phase = 0;
      while (random_count < RANDOM_ITEMS || phase < MIN_SETTINGS) begin
         random_setting(phase);
         n_rows = ((eff_h < 4) ? eff_h : 3) + $urandom_range(0, 1);
         for (int i = 0; i < n_rows; i++) begin
            send_source_row(truncated);
            if (truncated) break;
         end
         phase++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transactions (%0d randomized) over %0d register settings",
               total_items, random_count, settings_done);
      $display("compared %0d pixels: %0d early pulls, %0d frame ends, %0d dropped loads",
               pixels_checked, early_pulls, frame_ends, dropped_loads);
      if (pending != 0) $display("%0d expected pixels never arrived", pending);
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
